// ===== rtl/slx_pkg.sv =====
// ----------------------------------------------------------------------------
// slx_pkg: shared types and constants for the script lexer
// Token record, field widths, token kinds, operator and error codes.
// ----------------------------------------------------------------------------
package slx_pkg;

  localparam int CH_BITS     = 8;
  localparam int KIND_BITS   = 5;
  localparam int OP_BITS     = 3;
  localparam int ERR_BITS    = 2;
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // token kinds
  localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd0;
  localparam logic [KIND_BITS-1:0] K_NUMBER  = 5'd1;
  localparam logic [KIND_BITS-1:0] K_STRING  = 5'd2;
  localparam logic [KIND_BITS-1:0] K_ARITH   = 5'd3;
  localparam logic [KIND_BITS-1:0] K_CMP     = 5'd4;
  localparam logic [KIND_BITS-1:0] K_ASSIGN  = 5'd5;
  localparam logic [KIND_BITS-1:0] K_AND     = 5'd6;
  localparam logic [KIND_BITS-1:0] K_OR      = 5'd7;
  localparam logic [KIND_BITS-1:0] K_NOT     = 5'd8;
  localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd9;
  localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd10;
  localparam logic [KIND_BITS-1:0] K_LBRACE  = 5'd11;
  localparam logic [KIND_BITS-1:0] K_RBRACE  = 5'd12;
  localparam logic [KIND_BITS-1:0] K_LBRACK  = 5'd13;
  localparam logic [KIND_BITS-1:0] K_RBRACK  = 5'd14;
  localparam logic [KIND_BITS-1:0] K_COLON   = 5'd15;
  localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd16;
  localparam logic [KIND_BITS-1:0] K_DOT     = 5'd17;
  localparam logic [KIND_BITS-1:0] K_NEWLINE = 5'd18;
  localparam logic [KIND_BITS-1:0] K_END     = 5'd19;
  localparam logic [KIND_BITS-1:0] K_ERROR   = 5'd20;

  // arithmetic operator codes
  localparam logic [OP_BITS-1:0] OP_NONE = 3'd0;
  localparam logic [OP_BITS-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_MOD  = 3'd4;

  // compare operator codes
  localparam logic [OP_BITS-1:0] CMP_EQ = 3'd0;
  localparam logic [OP_BITS-1:0] CMP_NE = 3'd1;
  localparam logic [OP_BITS-1:0] CMP_LT = 3'd2;
  localparam logic [OP_BITS-1:0] CMP_LE = 3'd3;
  localparam logic [OP_BITS-1:0] CMP_GT = 3'd4;
  localparam logic [OP_BITS-1:0] CMP_GE = 3'd5;

  // error codes
  localparam logic [ERR_BITS-1:0] E_NONE   = 2'd0;
  localparam logic [ERR_BITS-1:0] E_STRING = 2'd1;
  localparam logic [ERR_BITS-1:0] E_BANG   = 2'd2;
  localparam logic [ERR_BITS-1:0] E_CHAR   = 2'd3;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OP_BITS-1:0]     op;
    logic [ERR_BITS-1:0]    err;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [LENGTH_BITS-1:0] len;
    logic                   last;
  } tok_t;

  // up to two tokens per character; v1 implies v0
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } lex_out_t;

endpackage

// ===== rtl/slx_lex.sv =====
// ----------------------------------------------------------------------------
// slx_lex: lexer state and per-character token logic
// Holds the scanner state; for each character forms up to two tokens.
// ----------------------------------------------------------------------------
module slx_lex (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [slx_pkg::CH_BITS-1:0]   ch,
  input  logic                          eoi,
  output slx_pkg::lex_out_t             res,
  output logic                          at_rest
);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_STRING = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_IDENT  = 3'd3;
  localparam logic [2:0] M_PENDOP = 3'd4;
  localparam logic [2:0] M_ERROR  = 3'd5;

  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_A    = 2'd1;
  localparam logic [1:0] KW_O    = 2'd2;
  localparam logic [1:0] KW_N    = 2'd3;

  localparam logic [1:0] P_EQ   = 2'd0;
  localparam logic [1:0] P_BANG = 2'd1;
  localparam logic [1:0] P_LT   = 2'd2;
  localparam logic [1:0] P_GT   = 2'd3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_UNDER = "_";

  localparam int LB = slx_pkg::LINE_BITS;
  localparam int CB = slx_pkg::COLUMN_BITS;
  localparam int NB = slx_pkg::LENGTH_BITS;

  logic [2:0]    mode_r, mode_nxt;
  logic          quote_r, quote_nxt;
  logic [1:0]    kw_r, kw_nxt;
  logic [1:0]    pop_r, pop_nxt;
  logic          ac_r, ac_nxt;
  logic [LB-1:0] cur_line_r, cur_line_nxt;
  logic [CB-1:0] cur_col_r, cur_col_nxt;
  logic [LB-1:0] tok_line_r, tok_line_nxt;
  logic [CB-1:0] tok_col_r, tok_col_nxt;
  logic [NB-1:0] tok_len_r, tok_len_nxt;

  logic [LB-1:0] line_inc;
  logic [CB-1:0] col_inc;
  logic [NB-1:0] len_inc;
  logic          is_dig, is_alpha, is_word, is_ws;
  logic          va, vb, do_start;
  slx_pkg::tok_t ta, tb, single_op, ident_tok;
  logic [slx_pkg::KIND_BITS-1:0] punct_kind;
  logic [slx_pkg::OP_BITS-1:0]   arith_op, two_op;
  logic          punct_hit, arith_hit;

  function automatic slx_pkg::tok_t mk(
    input logic [slx_pkg::KIND_BITS-1:0] kind,
    input logic [slx_pkg::OP_BITS-1:0]   op,
    input logic [slx_pkg::ERR_BITS-1:0]  err,
    input logic [LB-1:0]                 line,
    input logic [CB-1:0]                 col,
    input logic [NB-1:0]                 len
  );
    slx_pkg::tok_t t;
    t.kind = kind;
    t.op   = op;
    t.err  = err;
    t.line = line;
    t.col  = col;
    t.len  = len;
    t.last = 1'b0;
    return t;
  endfunction

  assign line_inc = (&cur_line_r) ? cur_line_r : cur_line_r + LB'(1);
  assign col_inc  = (&cur_col_r)  ? cur_col_r  : cur_col_r  + CB'(1);
  assign len_inc  = (&tok_len_r)  ? tok_len_r  : tok_len_r  + NB'(1);

  assign is_dig   = (ch >= "0") && (ch <= "9");
  assign is_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
  assign is_word  = is_alpha || is_dig || (ch == CH_UNDER);
  assign is_ws    = (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));

  always_comb begin
    arith_hit = 1'b1;
    arith_op  = slx_pkg::OP_ADD;
    case (ch)
      "+":     arith_op = slx_pkg::OP_ADD;
      "-":     arith_op = slx_pkg::OP_SUB;
      "*":     arith_op = slx_pkg::OP_MUL;
      "/":     arith_op = slx_pkg::OP_DIV;
      "%":     arith_op = slx_pkg::OP_MOD;
      default: arith_hit = 1'b0;
    endcase
  end

  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = slx_pkg::K_LPAREN;
    case (ch)
      "(":     punct_kind = slx_pkg::K_LPAREN;
      ")":     punct_kind = slx_pkg::K_RPAREN;
      "{":     punct_kind = slx_pkg::K_LBRACE;
      "}":     punct_kind = slx_pkg::K_RBRACE;
      "[":     punct_kind = slx_pkg::K_LBRACK;
      "]":     punct_kind = slx_pkg::K_RBRACK;
      ":":     punct_kind = slx_pkg::K_COLON;
      ",":     punct_kind = slx_pkg::K_COMMA;
      ".":     punct_kind = slx_pkg::K_DOT;
      default: punct_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (pop_r)
      P_EQ:    two_op = slx_pkg::CMP_EQ;
      P_BANG:  two_op = slx_pkg::CMP_NE;
      P_LT:    two_op = slx_pkg::CMP_LE;
      default: two_op = slx_pkg::CMP_GE;
    endcase
  end

  // one-character form of a pending '=', '<' or '>'
  always_comb begin
    if (pop_r == P_EQ) begin
      single_op = mk(slx_pkg::K_ASSIGN, slx_pkg::OP_NONE, slx_pkg::E_NONE,
                     tok_line_r, tok_col_r, NB'(1));
    end else begin
      single_op = mk(slx_pkg::K_CMP, (pop_r == P_LT) ? slx_pkg::CMP_LT : slx_pkg::CMP_GT,
                     slx_pkg::E_NONE, tok_line_r, tok_col_r, NB'(1));
    end
  end

  always_comb begin
    ident_tok = mk(slx_pkg::K_IDENT, slx_pkg::OP_NONE, slx_pkg::E_NONE,
                   tok_line_r, tok_col_r, tok_len_r);
    if (kw_r == KW_A && tok_len_r == NB'(3)) begin
      ident_tok.kind = slx_pkg::K_AND;
    end else if (kw_r == KW_O && tok_len_r == NB'(2)) begin
      ident_tok.kind = slx_pkg::K_OR;
    end else if (kw_r == KW_N && tok_len_r == NB'(3)) begin
      ident_tok.kind = slx_pkg::K_NOT;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    quote_nxt    = quote_r;
    kw_nxt       = kw_r;
    pop_nxt      = pop_r;
    ac_nxt       = ac_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_len_nxt  = tok_len_r;
    va           = 1'b0;
    vb           = 1'b0;
    ta           = '0;
    tb           = '0;
    do_start     = 1'b0;

    if (eoi) begin
      case (mode_r)
        M_STRING: begin
          va = 1'b1;
          ta = mk(slx_pkg::K_ERROR, slx_pkg::OP_NONE, slx_pkg::E_STRING,
                  tok_line_r, tok_col_r, '0);
        end
        M_NUMBER: begin
          va = 1'b1;
          ta = mk(slx_pkg::K_NUMBER, slx_pkg::OP_NONE, slx_pkg::E_NONE,
                  tok_line_r, tok_col_r, tok_len_r);
        end
        M_IDENT: begin
          va = 1'b1;
          ta = ident_tok;
        end
        M_PENDOP: begin
          va = 1'b1;
          if (pop_r == P_BANG) begin
            ta = mk(slx_pkg::K_ERROR, slx_pkg::OP_NONE, slx_pkg::E_BANG,
                    tok_line_r, tok_col_r, '0);
          end else begin
            ta = single_op;
          end
        end
        default: ;
      endcase
      // no end token once an error was or is being reported
      vb = !((mode_r == M_STRING) || (mode_r == M_ERROR) ||
             (mode_r == M_PENDOP && pop_r == P_BANG));
      tb = mk(slx_pkg::K_END, slx_pkg::OP_NONE, slx_pkg::E_NONE,
              cur_line_r, cur_col_r, '0);
      mode_nxt     = M_IDLE;
      quote_nxt    = 1'b0;
      kw_nxt       = KW_NONE;
      pop_nxt      = P_EQ;
      ac_nxt       = 1'b0;
      cur_line_nxt = LB'(1);
      cur_col_nxt  = CB'(1);
      tok_line_nxt = LB'(1);
      tok_col_nxt  = CB'(1);
      tok_len_nxt  = '0;
    end else begin
      case (mode_r)
        M_ERROR: ;
        M_STRING: begin
          if (ch == (quote_r ? CH_SQ : CH_DQ)) begin
            va = 1'b1;
            ta = mk(slx_pkg::K_STRING, slx_pkg::OP_NONE, slx_pkg::E_NONE,
                    tok_line_r, tok_col_r, tok_len_r);
            cur_col_nxt = col_inc;
            mode_nxt    = M_IDLE;
          end else if (ch == CH_NL) begin
            va = 1'b1;
            ta = mk(slx_pkg::K_ERROR, slx_pkg::OP_NONE, slx_pkg::E_STRING,
                    tok_line_r, tok_col_r, '0);
            mode_nxt = M_ERROR;
          end else begin
            tok_len_nxt = len_inc;
            cur_col_nxt = col_inc;
          end
        end
        M_NUMBER: begin
          if (is_dig) begin
            tok_len_nxt = len_inc;
            cur_col_nxt = col_inc;
          end else begin
            va = 1'b1;
            ta = mk(slx_pkg::K_NUMBER, slx_pkg::OP_NONE, slx_pkg::E_NONE,
                    tok_line_r, tok_col_r, tok_len_r);
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word) begin
            // keyword tracking checks the character at offset tok_len
            case (kw_r)
              KW_A: begin
                if (!((tok_len_r == NB'(1) && ch == "n") ||
                      (tok_len_r == NB'(2) && ch == "d"))) begin
                  kw_nxt = KW_NONE;
                end
              end
              KW_N: begin
                if (!((tok_len_r == NB'(1) && ch == "o") ||
                      (tok_len_r == NB'(2) && ch == "t"))) begin
                  kw_nxt = KW_NONE;
                end
              end
              KW_O: begin
                if (!(tok_len_r == NB'(1) && ch == "r")) begin
                  kw_nxt = KW_NONE;
                end
              end
              default: ;
            endcase
            tok_len_nxt = len_inc;
            cur_col_nxt = col_inc;
          end else begin
            va = 1'b1;
            ta = ident_tok;
            do_start = 1'b1;
          end
        end
        M_PENDOP: begin
          if (ch == CH_EQ) begin
            va = 1'b1;
            ta = mk(slx_pkg::K_CMP, two_op, slx_pkg::E_NONE,
                    tok_line_r, tok_col_r, NB'(2));
            cur_col_nxt = col_inc;
            mode_nxt    = M_IDLE;
          end else if (pop_r == P_BANG) begin
            va = 1'b1;
            ta = mk(slx_pkg::K_ERROR, slx_pkg::OP_NONE, slx_pkg::E_BANG,
                    tok_line_r, tok_col_r, '0);
            mode_nxt = M_ERROR;
          end else begin
            va = 1'b1;
            ta = single_op;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      // token start on the current character
      if (do_start) begin
        mode_nxt = M_IDLE;
        if (ac_r) begin
          if (ch == CH_NL) begin
            vb = 1'b1;
            tb = mk(slx_pkg::K_NEWLINE, slx_pkg::OP_NONE, slx_pkg::E_NONE,
                    cur_line_r, cur_col_r, NB'(1));
            cur_line_nxt = line_inc;
            cur_col_nxt  = CB'(1);
            ac_nxt       = 1'b0;
          end else begin
            cur_col_nxt = col_inc;
          end
        end else if (ch == CH_NL) begin
          cur_line_nxt = line_inc;
          cur_col_nxt  = CB'(1);
        end else if (is_ws) begin
          cur_col_nxt = col_inc;
        end else if (ch == CH_HASH) begin
          ac_nxt      = 1'b1;
          cur_col_nxt = col_inc;
        end else if (ch == CH_DQ || ch == CH_SQ) begin
          quote_nxt    = (ch == CH_SQ);
          mode_nxt     = M_STRING;
          tok_line_nxt = cur_line_r;
          tok_col_nxt  = cur_col_r;
          tok_len_nxt  = '0;
          cur_col_nxt  = col_inc;
        end else if (is_dig) begin
          mode_nxt     = M_NUMBER;
          tok_line_nxt = cur_line_r;
          tok_col_nxt  = cur_col_r;
          tok_len_nxt  = NB'(1);
          cur_col_nxt  = col_inc;
        end else if (is_alpha || ch == CH_UNDER) begin
          mode_nxt     = M_IDENT;
          tok_line_nxt = cur_line_r;
          tok_col_nxt  = cur_col_r;
          tok_len_nxt  = NB'(1);
          cur_col_nxt  = col_inc;
          kw_nxt = (ch == "a") ? KW_A : (ch == "o") ? KW_O : (ch == "n") ? KW_N : KW_NONE;
        end else if (arith_hit) begin
          vb = 1'b1;
          tb = mk(slx_pkg::K_ARITH, arith_op, slx_pkg::E_NONE,
                  cur_line_r, cur_col_r, NB'(1));
          cur_col_nxt = col_inc;
        end else if (ch == "=" || ch == "!" || ch == "<" || ch == ">") begin
          pop_nxt = (ch == "=") ? P_EQ : (ch == "!") ? P_BANG : (ch == "<") ? P_LT : P_GT;
          mode_nxt     = M_PENDOP;
          tok_line_nxt = cur_line_r;
          tok_col_nxt  = cur_col_r;
          tok_len_nxt  = NB'(1);
          cur_col_nxt  = col_inc;
        end else if (punct_hit) begin
          vb = 1'b1;
          tb = mk(punct_kind, slx_pkg::OP_NONE, slx_pkg::E_NONE,
                  cur_line_r, cur_col_r, NB'(1));
          cur_col_nxt = col_inc;
        end else begin
          vb = 1'b1;
          tb = mk(slx_pkg::K_ERROR, slx_pkg::OP_NONE, slx_pkg::E_CHAR,
                  cur_line_r, cur_col_r, '0);
          mode_nxt = M_ERROR;
        end
      end
    end
  end

  always_comb begin
    res.v0      = va | vb;
    res.v1      = va & vb;
    res.t0      = va ? ta : tb;
    res.t0.last = !(va & vb);
    res.t1      = tb;
    res.t1.last = 1'b1;
  end

  assign at_rest = (mode_r == M_IDLE) && !ac_r &&
                   (cur_line_r == LB'(1)) && (cur_col_r == CB'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      quote_r    <= 1'b0;
      kw_r       <= KW_NONE;
      pop_r      <= P_EQ;
      ac_r       <= 1'b0;
      cur_line_r <= LB'(1);
      cur_col_r  <= CB'(1);
      tok_line_r <= LB'(1);
      tok_col_r  <= CB'(1);
      tok_len_r  <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      quote_r    <= quote_nxt;
      kw_r       <= kw_nxt;
      pop_r      <= pop_nxt;
      ac_r       <= ac_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      tok_len_r  <= tok_len_nxt;
    end
  end

endmodule

// ===== rtl/slx_outq.sv =====
// ----------------------------------------------------------------------------
// slx_outq: token result queue
// Small register queue taking up to two tokens per cycle, one out per cycle.
// ----------------------------------------------------------------------------
module slx_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  slx_pkg::lex_out_t          din,
  input  logic                       pop,
  output slx_pkg::tok_t              head,
  output logic [slx_pkg::Q_AW:0]     cnt
);

  localparam int AW = slx_pkg::Q_AW;

  slx_pkg::tok_t   mem_r [slx_pkg::Q_DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            w0, w1;

  assign w0 = push & din.v0;
  assign w1 = push & din.v1;

  assign wp_nxt  = wp_r + AW'(w0) + AW'(w1);
  assign rp_nxt  = rp_r + AW'(pop);
  assign cnt_nxt = cnt_r + (AW+1)'(w0) + (AW+1)'(w1) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (w0) begin
      mem_r[wp_r] <= din.t0;
    end
    if (w1) begin
      mem_r[wp_r + AW'(1)] <= din.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head = mem_r[rp_r];
  assign cnt  = cnt_r;

endmodule

// ===== rtl/script_lexer_core.sv =====
// ----------------------------------------------------------------------------
// script_lexer_core: streaming lexer, one byte in per cycle unless stalled
// Turns a byte stream into tokens with kind, operator, position and length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one source byte per transaction in in_tdata; in_tlast
//   set marks end of source (the byte is then ignored), flushing any pending
//   token, emitting the end token if no error, and returning to start state.
//   Output channel out_*: one token per transaction; out_tlast marks the last
//   token caused by one input transaction. Bytes that cause no token (spaces,
//   comments, characters inside a token) produce no output transaction.
//   out_tvalid rises once an accepted byte has passed the input register and
//   the token logic has written its tokens to the result queue; a queue
//   without room holds the byte in the input register before that write.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and the receiver keeps out_tready high; a byte that closes one token and
//   emits another yields two tokens, which leave the 4-entry result queue at
//   one per cycle, so the output port bounds the rate to one token per cycle.
//   A stalled receiver fills the queue; input is held off once fewer than two
//   queue slots remain free.
//   Reset (rst_n low, synchronous) empties the queue and puts the lexer at
//   line 1, column 1 with no open token.
// ----------------------------------------------------------------------------
module script_lexer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [2:0] op_code, [4:3] error_code,
                                  // [20:5] start_line, [36:21] start_column,
                                  // [52:37] token_length, [55:53] zero
  output logic [4:0]  out_tuser,  // [4:0] token_kind
  output logic        out_tlast   // last
);

  localparam int AW = slx_pkg::Q_AW;

  logic                   v1_r;
  logic [7:0]             ch_r;
  logic                   eoi_r;
  logic                   fire;
  logic                   at_rest;
  logic [AW:0]            q_cnt;
  slx_pkg::lex_out_t      lex_res;
  slx_pkg::tok_t          head;

  assign fire      = v1_r && (q_cnt <= (AW+1)'(slx_pkg::Q_DEPTH - 2));
  assign in_tready = !v1_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r  <= in_tdata;
      eoi_r <= in_tlast;
    end
  end

  slx_lex u_lex (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .ch      (ch_r),
    .eoi     (eoi_r),
    .res     (lex_res),
    .at_rest (at_rest)
  );

  slx_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .din   (lex_res),
    .pop   (out_tvalid && out_tready),
    .head  (head),
    .cnt   (q_cnt)
  );

  assign out_tvalid = (q_cnt != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {3'b000, head.len, head.col, head.line, head.err, head.op};

  // queue never overflows
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= (AW+1)'(slx_pkg::Q_DEPTH))
    else $error("result queue overflow");

  // end of source puts the lexer back at its start state
  a_eoi_rest: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eoi_r |=> at_rest)
    else $error("lexer not at rest after end of source");

  // an accepted transaction is held in the input register next cycle
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted input transaction lost");

  // after a token leaves on the port the queue count stays within its depth
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> q_cnt <= (AW+1)'(slx_pkg::Q_DEPTH))
    else $error("queue count corrupt after pop");

endmodule
